// File: rtl/lpr_pkg.sv
// Shared types and constants for the longest-prefix route lookup core.
// Used by lpr_ctrl, lpr_dpath and longest_prefix_route_lookup_core; no dependencies.
package lpr_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int PORT_BITS     = 2;
  localparam int ADDR_W        = 32;
  localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int ENTRY_W       = 3 * ADDR_W + PORT_BITS;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

  // command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_INVAL  = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0]        entry_index;
    logic [ADDR_W-1:0] route_dest;
    logic [ADDR_W-1:0] route_mask;
    logic [ADDR_W-1:0] route_gateway;
    logic [1:0]        route_port;
    logic [ADDR_W-1:0] lookup_addr;
  } lpr_req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] next_hop;
    logic [1:0]        out_port;
    logic              was_write;
  } lpr_rsp_t;

  // one table row as stored in the RAM
  typedef struct packed {
    logic [ADDR_W-1:0]    dest;
    logic [ADDR_W-1:0]    mask;
    logic [ADDR_W-1:0]    gateway;
    logic [PORT_BITS-1:0] port;
  } lpr_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             wr_en;
    logic             inval_en;
    logic             scan_clr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } lpr_ctrl_t;

endpackage

// File: rtl/lpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lpr_ctrl.sv
// Control state machine of the route lookup core: accepts words, sequences the scan.
// Depends on lpr_pkg.
module lpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        req_cmd_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output lpr_pkg::lpr_ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [lpr_pkg::IDX_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    ctrl_o         = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_RESP;
          case (req_cmd_i)
            lpr_pkg::CMD_LOOKUP: begin
              ctrl_o.scan_clr = 1'b1;
              cnt_d           = '0;
              state_d         = S_SCAN;
            end
            lpr_pkg::CMD_WRITE: ctrl_o.wr_en = 1'b1;
            lpr_pkg::CMD_INVAL: ctrl_o.inval_en = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_addr = cnt_q;
        if (cnt_q == lpr_pkg::LAST_IDX) begin
          state_d = S_TAIL;
        end else begin
          cnt_d = cnt_q + lpr_pkg::IDX_W'(1);
        end
      end
      S_TAIL: state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESP);

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_cmd_i == lpr_pkg::CMD_WRITE || req_cmd_i == lpr_pkg::CMD_INVAL))
    |=> result_valid_o)
    else $error("write not acknowledged in the next cycle");

  a_lookup_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_cmd_i == lpr_pkg::CMD_LOOKUP) |=> (busy_o && !result_valid_o))
    else $error("lookup finished without scanning");

endmodule

// File: rtl/lpr_dpath.sv
// Datapath of the route lookup core: route table, valid bits, compare and best-match registers.
// Depends on lpr_pkg and lpr_ram.
module lpr_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpr_pkg::lpr_ctrl_t ctrl_i,
  input  lpr_pkg::lpr_req_t  req_i,
  output lpr_pkg::lpr_rsp_t  rsp_o
);

  logic [lpr_pkg::ROUTE_ENTRIES-1:0] valid_q;
  logic [lpr_pkg::IDX_W-1:0]         waddr;
  logic                              in_rng;
  lpr_pkg::lpr_entry_t               wentry;
  lpr_pkg::lpr_entry_t               rentry;

  logic                              cmp_vld_q;
  logic [lpr_pkg::IDX_W-1:0]         cmp_idx_q;
  logic                              match;

  logic [1:0]                        cmd_q;
  logic [lpr_pkg::ADDR_W-1:0]        addr_q;
  logic                              found_q;
  logic [lpr_pkg::ADDR_W-1:0]        best_mask_q;
  logic [lpr_pkg::ADDR_W-1:0]        best_gw_q;
  logic [lpr_pkg::PORT_BITS-1:0]     best_port_q;

  assign in_rng = (32'(req_i.entry_index) < lpr_pkg::ROUTE_ENTRIES);
  assign waddr  = lpr_pkg::IDX_W'(req_i.entry_index);

  always_comb begin
    wentry.dest    = req_i.route_dest;
    wentry.mask    = req_i.route_mask;
    wentry.gateway = req_i.route_gateway;
    wentry.port    = lpr_pkg::PORT_BITS'(req_i.route_port);
  end

  lpr_ram #(
    .WIDTH(lpr_pkg::ENTRY_W),
    .DEPTH(lpr_pkg::ROUTE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_en && in_rng),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(ctrl_i.rd_addr),
    .rdata_o(rentry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= ctrl_i.rd_en;
      if (ctrl_i.wr_en && in_rng) begin
        valid_q[waddr] <= 1'b1;
      end
      if (ctrl_i.inval_en && in_rng) begin
        valid_q[waddr] <= 1'b0;
      end
      if (ctrl_i.scan_clr) begin
        found_q <= 1'b0;
      end else if (match) begin
        found_q <= 1'b1;
      end
    end
  end

  // masked compare of the row read last cycle; ties go to the later (higher) slot
  assign match = cmp_vld_q && valid_q[cmp_idx_q]
              && (((addr_q ^ rentry.dest) & rentry.mask) == '0)
              && (rentry.mask >= best_mask_q);

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= ctrl_i.rd_addr;
    if (ctrl_i.load) begin
      cmd_q  <= req_i.cmd;
      addr_q <= req_i.lookup_addr;
    end
    if (ctrl_i.scan_clr) begin
      best_mask_q <= '0;
    end else if (match) begin
      best_mask_q <= rentry.mask;
      best_gw_q   <= rentry.gateway;
      best_port_q <= rentry.port;
    end
  end

  always_comb begin
    rsp_o = '0;
    case (cmd_q)
      lpr_pkg::CMD_LOOKUP: begin
        rsp_o.hit = found_q;
        if (found_q) begin
          rsp_o.next_hop = best_gw_q;
          rsp_o.out_port = 2'(best_port_q);
        end else begin
          rsp_o.next_hop = '1;
        end
      end
      lpr_pkg::CMD_WRITE: rsp_o.was_write = 1'b1;
      lpr_pkg::CMD_INVAL: rsp_o.was_write = 1'b1;
      default: ;
    endcase
  end

  a_found_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(found_q) |-> $past(ctrl_i.scan_clr))
    else $error("match flag dropped outside a scan start");

endmodule

// File: rtl/longest_prefix_route_lookup_core.sv
// Lookup: after acceptance the controller steps through S_SCAN, S_TAIL and S_RESP, and the result
// strobe comes in S_RESP; the scan reads one row per cycle through the table RAM's port.
// Write and invalidate: result in the cycle after acceptance; a new command is taken only once busy is low.
// busy is high from acceptance until the result cycle ends; the receiver cannot stall.
// Reset clears the valid bits and the controller at once; no clearing pass is needed.
// Depends on lpr_pkg, lpr_ctrl, lpr_dpath and lpr_ram.
module longest_prefix_route_lookup_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lpr_pkg::lpr_req_t req_i,
  output logic              result_valid_o,
  output lpr_pkg::lpr_rsp_t rsp_o
);

  lpr_pkg::lpr_ctrl_t ctrl;

  // sequence: accept the word, then for a lookup sweep the table, hold the best match, strobe the result
  lpr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_cmd_i     (req_i.cmd),
    .busy_o        (busy),
    .result_valid_o(result_valid_o),
    .ctrl_o        (ctrl)
  );

  // table storage, masked compare and the best-route registers
  lpr_dpath u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .req_i (req_i),
    .rsp_o (rsp_o)
  );

endmodule
